>>> hdl/bps_pkg.sv
package bps_pkg;

  localparam int unsigned CNT_W    = 32;
  localparam int unsigned FRAC_W   = 32;
  localparam int unsigned P_W      = FRAC_W + 1;
  localparam int unsigned Z_FRAC   = 28;
  localparam int unsigned ADDR_W   = 5;
  localparam int unsigned DATA_W   = 64;

  localparam logic [P_W-1:0] ONE       = 33'h1_0000_0000;
  localparam logic [22:0]    REL_SCALE = 23'd6553600;  // 100 with 16 fractional bits
  localparam logic [30:0]    Z1_RST    = 31'd526123830;
  localparam logic [30:0]    Z2_RST    = 31'd691443913;

  // cells in each chain
  localparam int unsigned P_STEPS  = FRAC_W;
  localparam int unsigned Q_STEPS  = 64;
  localparam int unsigned R_STEPS  = 32;
  localparam int unsigned S_STEPS  = 32;
  localparam int unsigned SIDE_LEN = Q_STEPS + S_STEPS;
  localparam int unsigned PIPE_LEN = 1 + P_STEPS + 3 + SIDE_LEN + 1;

  // register index, taken from paddr[4:3]
  localparam logic [1:0] REG_KNOWN = 2'd0;
  localparam logic [1:0] REG_Z1    = 2'd1;
  localparam logic [1:0] REG_Z2    = 2'd2;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_ZERO = 2'd1,
    ST_SAT  = 2'd2,
    ST_OVER = 2'd3
  } status_e;

  typedef struct packed {
    logic [32:0] rem;
    logic [63:0] num;
    logic [63:0] quo;
    logic [32:0] dsr;
  } div_t;

  typedef struct packed {
    logic [63:0] rad;
    logic [32:0] rem;
    logic [31:0] root;
  } sqrt_t;

  typedef struct packed {
    logic zero;
    logic over;
    logic eq;
  } flag_t;

  typedef struct packed {
    flag_t       fl;
    logic [32:0] p;
    logic [32:0] aerr;
    logic        relsat;
    logic [31:0] rel;
    logic [30:0] spread;
  } side_t;

  typedef struct packed {
    logic [32:0] proportion;
    logic [30:0] spread;
    logic [31:0] std_err;
    logic [32:0] abs_err;
    logic [31:0] rel_err_percent;
    logic [32:0] first_lower;
    logic [32:0] first_upper;
    logic [32:0] second_lower;
    logic [32:0] second_upper;
    status_e     status;
  } res_t;

endpackage

>>> hdl/bps_div_cell.sv
module bps_div_cell (
  input  logic          clk_i,
  input  logic          en_i,
  input  bps_pkg::div_t d_i,
  output bps_pkg::div_t d_o
);

  logic [33:0]   trial;
  logic [33:0]   diff;
  logic          take;
  bps_pkg::div_t d_d;
  bps_pkg::div_t d_q;

  // one restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    trial   = {d_i.rem, d_i.num[63]};
    diff    = trial - {1'b0, d_i.dsr};
    take    = (trial >= {1'b0, d_i.dsr});
    d_d.rem = take ? diff[32:0] : trial[32:0];
    d_d.num = {d_i.num[62:0], 1'b0};
    d_d.quo = {d_i.quo[62:0], take};
    d_d.dsr = d_i.dsr;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_q <= d_d;
    end
  end

  assign d_o = d_q;

endmodule

>>> hdl/bps_sqrt_cell.sv
module bps_sqrt_cell (
  input  logic           clk_i,
  input  logic           en_i,
  input  bps_pkg::sqrt_t s_i,
  output bps_pkg::sqrt_t s_o
);

  logic [34:0]    trial;
  logic [34:0]    cand;
  logic [34:0]    diff;
  logic           take;
  bps_pkg::sqrt_t s_d;
  bps_pkg::sqrt_t s_q;

  // one root bit per cell: bring down two radicand bits, try 4*root+1
  always_comb begin
    trial    = {s_i.rem, s_i.rad[63:62]};
    cand     = {1'b0, s_i.root, 2'b01};
    diff     = trial - cand;
    take     = (trial >= cand);
    s_d.rem  = take ? diff[32:0] : trial[32:0];
    s_d.rad  = {s_i.rad[61:0], 2'b00};
    s_d.root = {s_i.root[30:0], take};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s_q <= s_d;
    end
  end

  assign s_o = s_q;

endmodule

>>> hdl/binomial_proportion_stats.sv
// Throughput: one pair per cycle, set by the chains of divide and root cells,
//   one quotient or root bit per cell, all stepping together; the whole
//   pipeline stalls while the output queue is full and not being read.
// A two-entry output queue keeps input open while one result waits.
// Reset clears all valid flags and the queue, and loads the default registers
//   (known probability 0, z values for 95 and 99 percent).
module binomial_proportion_stats (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] true_count_i,
  input  logic [31:0] total_count_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [32:0] proportion_o,
  output logic [30:0] spread_o,
  output logic [31:0] std_err_o,
  output logic [32:0] abs_err_o,
  output logic [31:0] rel_err_percent_o,
  output logic [32:0] first_lower_o,
  output logic [32:0] first_upper_o,
  output logic [32:0] second_lower_o,
  output logic [32:0] second_upper_o,
  output logic [1:0]  status_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  localparam int unsigned PL = bps_pkg::PIPE_LEN;
  localparam int unsigned PS = bps_pkg::P_STEPS;
  localparam int unsigned QS = bps_pkg::Q_STEPS;
  localparam int unsigned RS = bps_pkg::R_STEPS;
  localparam int unsigned SS = bps_pkg::S_STEPS;
  localparam int unsigned SL = bps_pkg::SIDE_LEN;

  function automatic logic [65:0] wald(logic [32:0] p, logic [62:0] prod);
    logic [34:0] m;
    logic [35:0] sum;
    logic [32:0] lo;
    logic [32:0] hi;
    m   = prod[62:bps_pkg::Z_FRAC];
    lo  = (m >= {2'b00, p}) ? '0 : (p - m[32:0]);
    sum = {3'b000, p} + {1'b0, m};
    hi  = (sum > {3'b000, bps_pkg::ONE}) ? bps_pkg::ONE : sum[32:0];
    return {lo, hi};
  endfunction

  logic en;
  logic [PL-1:0] vld_q;

  // configuration
  logic [32:0] known_q;
  logic [30:0] z1_q;
  logic [30:0] z2_q;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      known_q <= '0;
      z1_q    <= bps_pkg::Z1_RST;
      z2_q    <= bps_pkg::Z2_RST;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[4:3])
        bps_pkg::REG_KNOWN: known_q <= pwdata[32:0];
        bps_pkg::REG_Z1:    z1_q    <= pwdata[30:0];
        bps_pkg::REG_Z2:    z2_q    <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:3])
      bps_pkg::REG_KNOWN: prdata = {31'b0, known_q};
      bps_pkg::REG_Z1:    prdata = {33'b0, z1_q};
      bps_pkg::REG_Z2:    prdata = {33'b0, z2_q};
      default:            prdata = '0;
    endcase
  end

  // valid line, all stages step together
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[PL-2:0], in_valid_i};
    end
  end

  assign in_ready_o = en;

  // input stage: clamp the count, flag corner cases
  logic           over;
  logic [31:0]    t_clamp;
  bps_pkg::div_t  s0_div_q;
  bps_pkg::flag_t s0_fl_q;

  assign over    = (true_count_i > total_count_i);
  assign t_clamp = over ? total_count_i : true_count_i;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_div_q.rem  <= {1'b0, t_clamp};
      s0_div_q.num  <= '0;
      s0_div_q.quo  <= '0;
      s0_div_q.dsr  <= {1'b0, total_count_i};
      s0_fl_q.zero  <= (total_count_i == '0);
      s0_fl_q.over  <= over;
      s0_fl_q.eq    <= (t_clamp == total_count_i);
    end
  end

  // proportion chain
  bps_pkg::div_t  p_chain [PS];
  bps_pkg::flag_t f1_q    [PS];

  for (genvar k = 0; k < PS; k++) begin : g_pdiv
    if (k == 0) begin : g_first
      bps_div_cell u_cell (.clk_i, .en_i(en), .d_i(s0_div_q), .d_o(p_chain[k]));
      always_ff @(posedge clk_i) begin
        if (en) f1_q[k] <= s0_fl_q;
      end
    end else begin : g_rest
      bps_div_cell u_cell (.clk_i, .en_i(en), .d_i(p_chain[k-1]), .d_o(p_chain[k]));
      always_ff @(posedge clk_i) begin
        if (en) f1_q[k] <= f1_q[k-1];
      end
    end
  end

  // S1: proportion
  logic [32:0]    p_s1_q;
  logic [31:0]    n_s1_q;
  bps_pkg::flag_t fl_s1_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_s1_q  <= f1_q[PS-1].eq ? bps_pkg::ONE : {1'b0, p_chain[PS-1].quo[31:0]};
      n_s1_q  <= p_chain[PS-1].dsr[31:0];
      fl_s1_q <= f1_q[PS-1];
    end
  end

  // S2: p(1-p) and absolute error
  logic [32:0]    one_minus;
  logic [63:0]    num_full;
  logic [63:0]    num_s2_q;
  logic [32:0]    aerr_s2_q;
  logic [32:0]    p_s2_q;
  logic [31:0]    n_s2_q;
  bps_pkg::flag_t fl_s2_q;

  assign one_minus = bps_pkg::ONE - p_s1_q;
  assign num_full  = {32'b0, p_s1_q[31:0]} * {31'b0, one_minus};

  always_ff @(posedge clk_i) begin
    if (en) begin
      num_s2_q  <= num_full;
      aerr_s2_q <= (p_s1_q >= known_q) ? (p_s1_q - known_q) : (known_q - p_s1_q);
      p_s2_q    <= p_s1_q;
      n_s2_q    <= n_s1_q;
      fl_s2_q   <= fl_s1_q;
    end
  end

  // S3: scale the error, set up both dividers
  logic [55:0]    rel_prod;
  logic           relsat;
  bps_pkg::div_t  s3_q_q;
  bps_pkg::div_t  s3_r_q;
  bps_pkg::side_t s3_side_q;

  assign rel_prod = {23'b0, aerr_s2_q} * {33'b0, bps_pkg::REL_SCALE};
  // quotient overflows 32 bits when the top part already reaches the divisor
  assign relsat   = ({9'b0, rel_prod[55:32]} >= known_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_q_q.rem       <= '0;
      s3_q_q.num       <= num_s2_q;
      s3_q_q.quo       <= '0;
      s3_q_q.dsr       <= {1'b0, n_s2_q};
      s3_r_q.rem       <= relsat ? '0 : {9'b0, rel_prod[55:32]};
      s3_r_q.num       <= {rel_prod[31:0], 32'b0};
      s3_r_q.quo       <= '0;
      s3_r_q.dsr       <= known_q;
      s3_side_q.fl     <= fl_s2_q;
      s3_side_q.p      <= p_s2_q;
      s3_side_q.aerr   <= aerr_s2_q;
      s3_side_q.relsat <= relsat;
      s3_side_q.rel    <= '0;
      s3_side_q.spread <= '0;
    end
  end

  // variance and relative error chains
  bps_pkg::div_t q_chain [QS];
  bps_pkg::div_t r_chain [RS];

  for (genvar k = 0; k < QS; k++) begin : g_qdiv
    if (k == 0) begin : g_first
      bps_div_cell u_cell (.clk_i, .en_i(en), .d_i(s3_q_q), .d_o(q_chain[k]));
    end else begin : g_rest
      bps_div_cell u_cell (.clk_i, .en_i(en), .d_i(q_chain[k-1]), .d_o(q_chain[k]));
    end
  end

  for (genvar k = 0; k < RS; k++) begin : g_rdiv
    if (k == 0) begin : g_first
      bps_div_cell u_cell (.clk_i, .en_i(en), .d_i(s3_r_q), .d_o(r_chain[k]));
    end else begin : g_rest
      bps_div_cell u_cell (.clk_i, .en_i(en), .d_i(r_chain[k-1]), .d_o(r_chain[k]));
    end
  end

  // standard error chain
  bps_pkg::sqrt_t sq_in;
  bps_pkg::sqrt_t sq_chain [SS];

  assign sq_in.rad  = q_chain[QS-1].quo;
  assign sq_in.rem  = '0;
  assign sq_in.root = '0;

  for (genvar k = 0; k < SS; k++) begin : g_sqrt
    if (k == 0) begin : g_first
      bps_sqrt_cell u_cell (.clk_i, .en_i(en), .s_i(sq_in), .s_o(sq_chain[k]));
    end else begin : g_rest
      bps_sqrt_cell u_cell (.clk_i, .en_i(en), .s_i(sq_chain[k-1]), .s_o(sq_chain[k]));
    end
  end

  // side data riding along with the chains
  bps_pkg::side_t sc_q [1:SL];

  for (genvar k = 1; k <= SL; k++) begin : g_side
    bps_pkg::side_t nxt;
    if (k == 1) begin : g_first
      assign nxt = s3_side_q;
    end else if (k == RS + 1) begin : g_rel
      always_comb begin
        nxt     = sc_q[k-1];
        nxt.rel = r_chain[RS-1].quo[31:0];
      end
    end else if (k == QS + 1) begin : g_spread
      always_comb begin
        nxt        = sc_q[k-1];
        nxt.spread = q_chain[QS-1].quo[62:32];
      end
    end else begin : g_plain
      assign nxt = sc_q[k-1];
    end
    always_ff @(posedge clk_i) begin
      if (en) sc_q[k] <= nxt;
    end
  end

  // S4: margin products
  logic [31:0]    se;
  logic [62:0]    m1_s4_q;
  logic [62:0]    m2_s4_q;
  logic [31:0]    se_s4_q;
  bps_pkg::side_t side_s4_q;

  assign se = sq_chain[SS-1].root;

  always_ff @(posedge clk_i) begin
    if (en) begin
      m1_s4_q   <= {32'b0, z1_q} * {31'b0, se};
      m2_s4_q   <= {32'b0, z2_q} * {31'b0, se};
      se_s4_q   <= se;
      side_s4_q <= sc_q[SL];
    end
  end

  // final assembly
  logic [65:0]   iv1;
  logic [65:0]   iv2;
  bps_pkg::res_t res;

  assign iv1 = wald(side_s4_q.p, m1_s4_q);
  assign iv2 = wald(side_s4_q.p, m2_s4_q);

  always_comb begin
    if (side_s4_q.fl.zero) begin
      res        = '0;
      res.status = bps_pkg::ST_ZERO;
    end else begin
      res.proportion      = side_s4_q.p;
      res.spread          = side_s4_q.spread;
      res.std_err         = se_s4_q;
      res.abs_err         = side_s4_q.aerr;
      res.rel_err_percent = side_s4_q.relsat ? '1 : side_s4_q.rel;
      res.first_lower     = iv1[65:33];
      res.first_upper     = iv1[32:0];
      res.second_lower    = iv2[65:33];
      res.second_upper    = iv2[32:0];
      if (side_s4_q.fl.over) begin
        res.status = bps_pkg::ST_OVER;
      end else if (side_s4_q.relsat) begin
        res.status = bps_pkg::ST_SAT;
      end else begin
        res.status = bps_pkg::ST_OK;
      end
    end
  end

  // two-entry output queue
  bps_pkg::res_t fifo_q [2];
  logic          wr_q;
  logic          rd_q;
  logic [1:0]    cnt_q;
  logic          push;
  logic          pop;

  assign en   = (cnt_q != 2'd2) || out_ready_i;
  assign push = vld_q[PL-1] && en;
  assign pop  = (cnt_q != 2'd0) && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (pop)  rd_q <= ~rd_q;
      if (push && !pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) fifo_q[wr_q] <= res;
  end

  assign out_valid_o       = (cnt_q != 2'd0);
  assign proportion_o      = fifo_q[rd_q].proportion;
  assign spread_o          = fifo_q[rd_q].spread;
  assign std_err_o         = fifo_q[rd_q].std_err;
  assign abs_err_o         = fifo_q[rd_q].abs_err;
  assign rel_err_percent_o = fifo_q[rd_q].rel_err_percent;
  assign first_lower_o     = fifo_q[rd_q].first_lower;
  assign first_upper_o     = fifo_q[rd_q].first_upper;
  assign second_lower_o    = fifo_q[rd_q].second_lower;
  assign second_upper_o    = fifo_q[rd_q].second_upper;
  assign status_o          = fifo_q[rd_q].status;

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("output queue count out of range");

  a_hold_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[PL-1] && !en) |=> vld_q[PL-1])
    else $error("stalled result dropped from pipeline");

  a_zero_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == bps_pkg::ST_ZERO) |->
      (proportion_o == '0 && std_err_o == '0 && first_upper_o == '0))
    else $error("zero total result not cleared");

  a_interval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != bps_pkg::ST_ZERO) |->
      (first_lower_o <= proportion_o && first_upper_o >= proportion_o &&
       second_lower_o <= proportion_o && second_upper_o >= proportion_o))
    else $error("interval does not contain the proportion");

  a_queue_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd2 && !out_ready_i) |-> !in_ready_o)
    else $error("input taken with full output queue");

endmodule

>>> verif/tb_binomial_proportion_stats.sv
module tb_binomial_proportion_stats;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [31:0] true_count_i;
  logic [31:0] total_count_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [32:0] proportion_o;
  logic [30:0] spread_o;
  logic [31:0] std_err_o;
  logic [32:0] abs_err_o;
  logic [31:0] rel_err_percent_o;
  logic [32:0] first_lower_o;
  logic [32:0] first_upper_o;
  logic [32:0] second_lower_o;
  logic [32:0] second_upper_o;
  logic [1:0]  status_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;

  binomial_proportion_stats DUT (.*);

  localparam int unsigned LATENCY = 133;
  localparam longint unsigned CYCLE_LIMIT = 400000;

  typedef struct {
    logic [31:0]   tc;
    logic [31:0]   nc;
    bit            has_exp;
    bps_pkg::res_t exp;
  } row_t;

  logic [32:0] known_q;
  logic [30:0] z1_q;
  logic [30:0] z2_q;

  bps_pkg::res_t stats_q[$];
  int            errors = 0;
  longint        cycles = 0;
  int            out_wait;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("binomial_proportion_stats test failed");
      $finish;
    end
  end

  function automatic logic [63:0] isqrt128(logic [127:0] x);
    logic [63:0]  r;
    logic [63:0]  c;
    logic [127:0] sq;
    r = '0;
    for (int b = 48; b >= 0; b--) begin
      c = r | (64'd1 << b);
      sq = 128'(c) * 128'(c);
      if (sq <= x) r = c;
    end
    return r;
  endfunction

  function automatic void wald_limits(logic [32:0] p, logic [63:0] se, logic [30:0] z,
                                      output logic [32:0] lo, output logic [32:0] hi);
    logic [127:0] prod;
    logic [63:0]  m;
    logic [64:0]  sum;
    prod = 128'(z) * 128'(se);
    m = 64'(prod >> bps_pkg::Z_FRAC);
    lo = (m >= 64'(p)) ? 33'd0 : 33'(64'(p) - m);
    sum = 65'(p) + 65'(m);
    hi = (sum > 65'(bps_pkg::ONE)) ? bps_pkg::ONE : 33'(sum);
  endfunction

  function automatic bps_pkg::res_t predict_stats(logic [31:0] tc, logic [31:0] nc);
    bps_pkg::res_t    r;
    logic [31:0]      t;
    logic [32:0]      p;
    logic [127:0]     q;
    logic [63:0]      se;
    logic [127:0]     rq;
    bps_pkg::status_e st;
    r = '0;
    if (nc == 0) begin
      r.status = bps_pkg::ST_ZERO;
      return r;
    end
    st = bps_pkg::ST_OK;
    t = tc;
    if (t > nc) begin
      t = nc;
      st = bps_pkg::ST_OVER;
    end
    if (t == nc) p = bps_pkg::ONE;
    else begin
      p = 33'((64'(t) << bps_pkg::FRAC_W) / 64'(nc));
    end
    q = (128'(p) * 128'(bps_pkg::ONE - p)) / 128'(nc);
    se = isqrt128(q);
    r.proportion = p;
    r.spread = 31'(q >> bps_pkg::FRAC_W);
    r.std_err = se[31:0];
    r.abs_err = (p >= known_q) ? p - known_q : known_q - p;
    if (known_q == 0) begin
      r.rel_err_percent = '1;
      if (st == bps_pkg::ST_OK) st = bps_pkg::ST_SAT;
    end else begin
      rq = (128'(r.abs_err) * 128'(bps_pkg::REL_SCALE)) / 128'(known_q);
      if (rq > 128'hFFFF_FFFF) begin
        r.rel_err_percent = '1;
        if (st == bps_pkg::ST_OK) st = bps_pkg::ST_SAT;
      end else r.rel_err_percent = rq[31:0];
    end
    wald_limits(p, se, z1_q, r.first_lower, r.first_upper);
    wald_limits(p, se, z2_q, r.second_lower, r.second_upper);
    r.status = st;
    return r;
  endfunction

  task automatic write_reg(logic [1:0] idx, logic [63:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      bps_pkg::REG_KNOWN: known_q = val[32:0];
      bps_pkg::REG_Z1:    z1_q = val[30:0];
      bps_pkg::REG_Z2:    z2_q = val[30:0];
      default: ;
    endcase
    // bus returns to idle before the next transfer
    @(posedge clk_i);
  endtask

  task automatic send_pair(logic [31:0] tc, logic [31:0] nc, bit has_exp,
                           bps_pkg::res_t exp);
    bps_pkg::res_t pred;
    int            gap;
    gap = $urandom_range(0, 5);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    pred = predict_stats(tc, nc);
    if (has_exp && pred !== exp) begin
      $display("%0t predictor row mismatch: expected %h actual %h", $time, exp, pred);
      errors++;
    end
    stats_q.push_back(pred);
    in_valid_i    <= 1'b1;
    true_count_i  <= tc;
    total_count_i <= nc;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (stats_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_count();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 16);
      1: return $urandom_range(0, 1000);
      2: return 32'hFFFF_FFFF - $urandom_range(0, 16);
      default: return $urandom();
    endcase
  endfunction

  // draw a random wait for every beat, hold ready low until the wait has counted down
  always @(posedge clk_i) begin
    int w;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      out_wait    <= $urandom_range(0, 5);
    end else if (out_valid_o && out_ready_i) begin
      w = $urandom_range(0, 5);
      out_wait    <= w;
      out_ready_i <= (w == 0);
    end else if (out_wait != 0) begin
      out_wait    <= out_wait - 1;
      out_ready_i <= (out_wait == 1);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    bps_pkg::res_t got;
    bps_pkg::res_t exp;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.proportion      = proportion_o;
      got.spread          = spread_o;
      got.std_err         = std_err_o;
      got.abs_err         = abs_err_o;
      got.rel_err_percent = rel_err_percent_o;
      got.first_lower     = first_lower_o;
      got.first_upper     = first_upper_o;
      got.second_lower    = second_lower_o;
      got.second_upper    = second_upper_o;
      got.status          = bps_pkg::status_e'(status_o);
      if (stats_q.size() == 0) begin
        $display("%0t unexpected beat: expected none actual %h", $time, got);
        errors++;
      end else begin
        exp = stats_q.pop_front();
        if (got.proportion !== exp.proportion) begin
          $display("%0t proportion: expected %h actual %h", $time, exp.proportion,
                   got.proportion);
          errors++;
        end
        if (got.spread !== exp.spread) begin
          $display("%0t spread: expected %h actual %h", $time, exp.spread, got.spread);
          errors++;
        end
        if (got.std_err !== exp.std_err) begin
          $display("%0t std_err: expected %h actual %h", $time, exp.std_err, got.std_err);
          errors++;
        end
        if (got.abs_err !== exp.abs_err) begin
          $display("%0t abs_err: expected %h actual %h", $time, exp.abs_err, got.abs_err);
          errors++;
        end
        if (got.rel_err_percent !== exp.rel_err_percent) begin
          $display("%0t rel_err_percent: expected %h actual %h", $time,
                   exp.rel_err_percent, got.rel_err_percent);
          errors++;
        end
        if (got.first_lower !== exp.first_lower) begin
          $display("%0t first_lower: expected %h actual %h", $time, exp.first_lower,
                   got.first_lower);
          errors++;
        end
        if (got.first_upper !== exp.first_upper) begin
          $display("%0t first_upper: expected %h actual %h", $time, exp.first_upper,
                   got.first_upper);
          errors++;
        end
        if (got.second_lower !== exp.second_lower) begin
          $display("%0t second_lower: expected %h actual %h", $time, exp.second_lower,
                   got.second_lower);
          errors++;
        end
        if (got.second_upper !== exp.second_upper) begin
          $display("%0t second_upper: expected %h actual %h", $time, exp.second_upper,
                   got.second_upper);
          errors++;
        end
        if (status_o !== exp.status) begin
          $display("%0t status: expected %0d actual %0d", $time, exp.status, status_o);
          errors++;
        end
      end
    end
  end

  initial begin
    row_t          rows[$];
    row_t          rw;
    bps_pkg::res_t zero_res;
    bps_pkg::res_t none;
    logic [31:0]   n;
    logic [31:0]   t;
    int            mode;

    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    true_count_i = '0;
    total_count_i = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    known_q = '0;
    z1_q = bps_pkg::Z1_RST;
    z2_q = bps_pkg::Z2_RST;
    none = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // zero total: everything clears, status flags it
    zero_res = '0;
    zero_res.status = bps_pkg::ST_ZERO;
    rows.push_back('{32'd0, 32'd0, 1'b1, zero_res});
    rows.push_back('{32'hFFFF_FFFF, 32'd0, 1'b1, zero_res});
    // known = 0 after reset, so rel saturates
    rw = '{32'd5, 32'd5, 1'b1, '0};
    rw.exp.proportion = bps_pkg::ONE; rw.exp.abs_err = bps_pkg::ONE;
    rw.exp.rel_err_percent = '1;
    rw.exp.first_lower = bps_pkg::ONE; rw.exp.first_upper = bps_pkg::ONE;
    rw.exp.second_lower = bps_pkg::ONE; rw.exp.second_upper = bps_pkg::ONE;
    rw.exp.status = bps_pkg::ST_SAT;
    rows.push_back(rw);
    rw.tc = 32'd9; rw.exp.status = bps_pkg::ST_OVER;
    rows.push_back(rw);
    rw = '{32'd0, 32'd7, 1'b1, '0};
    rw.exp.rel_err_percent = '1; rw.exp.status = bps_pkg::ST_SAT;
    rows.push_back(rw);
    rows.push_back('{32'd1, 32'd2, 1'b0, none});
    rows.push_back('{32'd1, 32'd3, 1'b0, none});
    rows.push_back('{32'd1, 32'hFFFF_FFFF, 1'b0, none});
    rows.push_back('{32'hFFFF_FFFE, 32'hFFFF_FFFF, 1'b0, none});
    rows.push_back('{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, none});
    rows.push_back('{32'hFFFF_FFFF, 32'd1, 1'b0, none});
    rows.push_back('{32'h5555_5555, 32'hAAAA_AAAA, 1'b0, none});
    foreach (rows[i]) send_pair(rows[i].tc, rows[i].nc, rows[i].has_exp, rows[i].exp);
    drain();

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin
          write_reg(bps_pkg::REG_KNOWN, 64'h8000_0000);
        end
        1: begin
          write_reg(bps_pkg::REG_KNOWN, 64'h1_0000_0000);
          write_reg(bps_pkg::REG_Z1, 64'h7FFF_FFFF);
          write_reg(bps_pkg::REG_Z2, 64'd0);
        end
        2: begin
          write_reg(bps_pkg::REG_KNOWN, 64'd1);
          write_reg(bps_pkg::REG_Z1, 64'd0);
          write_reg(bps_pkg::REG_Z2, 64'h7FFF_FFFF);
        end
        3: begin
          write_reg(bps_pkg::REG_KNOWN, {$urandom(), $urandom()} & 64'h1_FFFF_FFFF);
          write_reg(bps_pkg::REG_Z1, 64'($urandom()) & 64'h7FFF_FFFF);
          write_reg(bps_pkg::REG_Z2, 64'($urandom()) & 64'h7FFF_FFFF);
        end
        4: begin
          write_reg(bps_pkg::REG_KNOWN, 64'h1_FFFF_FFFF);
          write_reg(bps_pkg::REG_Z1, 64'(bps_pkg::Z1_RST));
          write_reg(bps_pkg::REG_Z2, 64'(bps_pkg::Z2_RST));
        end
        default: begin
          write_reg(bps_pkg::REG_KNOWN, 64'h2000_0000);
        end
      endcase
      for (int k = 0; k < 305; k++) begin
        mode = $urandom_range(0, 9);
        n = rand_count();
        if (mode == 0) t = $urandom();
        else if (mode == 1) t = n + 1 + $urandom_range(0, 3);
        else if (mode == 2) t = (n == 0) ? 0 : n - $urandom_range(0, 1);
        else if (n == 0) t = $urandom_range(0, 3);
        else t = $urandom_range(0, n);
        if (mode == 3) n = 0;
        send_pair(t, n, 1'b0, none);
      end
      drain();
    end

    if (errors == 0) begin
      $display("binomial_proportion_stats test passed");
    end else begin
      $display("binomial_proportion_stats test failed");
    end
    $finish;
  end

endmodule
